// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the name table unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CHNT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CHNT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/chnt_pkg.sv =====
// Types, constants and codes of the chained hash name table unit.
// No dependencies; used by every module of the block except chnt_ram.
`default_nettype none
package chnt_pkg;
    localparam int NAME_LEN_DEF = 16;
    localparam int BUCKETS_DEF  = 64;
    localparam int ENTRIES_DEF  = 64;
    localparam int CHAR_W       = 7;
    localparam int TID_W        = 16;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int HASH_W       = 32;
    localparam int QDEPTH       = 2;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WHOIS    = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_BKT,
        S_BKTD,
        S_ERD,
        S_ECMP,
        S_FIN,
        S_LINK
    } t_state;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_bstat;
endpackage
`default_nettype wire

// ===== rtl/core/chnt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the bucket heads and the entry pool.
`default_nettype none
module chnt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                  i_wdata,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                       o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/chnt_fifo.sv =====
// Short request queue between the front and the back of the name table.
// Depends on chnt_pkg for its depth.
`default_nettype none
module chnt_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PW = (chnt_pkg::QDEPTH > 1) ? $clog2(chnt_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(chnt_pkg::QDEPTH + 1);

    logic [W-1:0]  r_buf [chnt_pkg::QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_data  = r_buf[r_rd];
    assign o_full  = (r_cnt == CW'(chnt_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_buf[r_wr] <= i_data;
                r_wr <= (r_wr == PW'(chnt_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(chnt_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/chnt_front.sv =====
// Front of the name table: collects name characters and the djb2 hash.
// Depends on chnt_pkg; feeds whole requests into chnt_fifo.
`default_nettype none
module chnt_front #(
    parameter int NAME_LEN = chnt_pkg::NAME_LEN_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [chnt_pkg::CHAR_W-1:0]      i_char,
    input  wire logic                             i_last,
    input  wire logic [chnt_pkg::MODE_W-1:0]      i_mode,
    input  wire logic [chnt_pkg::TID_W-1:0]       i_tid,
    input  wire logic                             i_q_full,
    input  wire chnt_pkg::t_bstat                 i_bstat,
    output logic                                  o_q_push,
    output logic [chnt_pkg::TID_W + chnt_pkg::MODE_W + NAME_LEN*chnt_pkg::CHAR_W
                  + chnt_pkg::HASH_W - 1:0]       o_q_data
);
    localparam int NW  = NAME_LEN * chnt_pkg::CHAR_W;
    localparam int LW  = $clog2(NAME_LEN + 1);
    localparam int NIW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;

    logic [LW-1:0]                r_len, n_len;
    logic [chnt_pkg::HASH_W-1:0]  r_hash, n_hash;
    logic [NW-1:0]                r_name, n_name;
    logic                         keep, accept;

    assign o_ready = !i_q_full && !i_bstat.clearing;
    assign accept  = i_valid && o_ready;
    assign keep    = (i_char != '0) && (r_len < LW'(NAME_LEN));

    always_comb begin
        n_len  = r_len;
        n_hash = r_hash;
        n_name = r_name;
        if (keep) begin
            n_len  = r_len + 1'b1;
            n_hash = (r_hash << 5) + r_hash
                   + {{(chnt_pkg::HASH_W - chnt_pkg::CHAR_W){1'b0}}, i_char};
            for (int i = 0; i < NAME_LEN; i++) begin
                if (r_len[NIW-1:0] == NIW'(i)) begin
                    n_name[i*chnt_pkg::CHAR_W +: chnt_pkg::CHAR_W] = i_char;
                end
            end
        end
    end

    assign o_q_push = accept && i_last;
    assign o_q_data = {i_tid, i_mode, n_name, n_hash};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_hash <= chnt_pkg::HASH_SEED;
            r_name <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_len  <= '0;
                r_hash <= chnt_pkg::HASH_SEED;
                r_name <= '0;
            end else begin
                r_len  <= n_len;
                r_hash <= n_hash;
                r_name <= n_name;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/chnt_back.sv =====
// Back of the name table: bucket reduction, chain walk, update and result.
// Depends on chnt_pkg and chnt_ram; takes requests from chnt_fifo.
`default_nettype none
module chnt_back #(
    parameter int NAME_LEN = chnt_pkg::NAME_LEN_DEF,
    parameter int BUCKETS  = chnt_pkg::BUCKETS_DEF,
    parameter int ENTRIES  = chnt_pkg::ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_q_empty,
    output logic                                  o_q_pop,
    input  wire logic [chnt_pkg::TID_W + chnt_pkg::MODE_W + NAME_LEN*chnt_pkg::CHAR_W
                       + chnt_pkg::HASH_W - 1:0]  i_q_data,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [chnt_pkg::STATUS_W-1:0]         o_status,
    output logic [chnt_pkg::TID_W-1:0]            o_tid,
    output chnt_pkg::t_bstat                      o_bstat
);
    localparam int NW  = NAME_LEN * chnt_pkg::CHAR_W;
    localparam int HW  = chnt_pkg::HASH_W;
    localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int XW  = BIW + 5;
    localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNW = $clog2(ENTRIES + 1);
    localparam int CW  = (BIW > 3) ? BIW : 3;

    chnt_pkg::t_state r_state, n_state;

    logic [CW-1:0]                r_cnt;
    logic [HW-1:0]                r_hash;
    logic [BIW-1:0]               r_rem;
    logic [XW-1:0]                red;
    logic [NW-1:0]                r_name;
    logic [chnt_pkg::MODE_W-1:0]  r_mode;
    logic [chnt_pkg::TID_W-1:0]   r_tid, r_fid;
    logic [EIW-1:0]               r_cur, r_tail;
    logic                         r_have_tail, r_found;
    logic [CNW-1:0]               r_count;
    logic                         r_out_valid;
    logic [chnt_pkg::STATUS_W-1:0] r_status;
    logic [chnt_pkg::TID_W-1:0]   r_tid_out;

    logic                         full, append, match;
    logic [EIW-1:0]               new_idx;

    logic                         b_we;
    logic [BIW-1:0]               b_waddr;
    logic [EIW:0]                 b_wdata, b_rdata;
    logic                         n_we, i_we, l_we;
    logic [EIW-1:0]               i_waddr, l_waddr;
    logic [NW-1:0]                n_rdata;
    logic [chnt_pkg::TID_W-1:0]   i_rdata;
    logic [EIW:0]                 l_wdata, l_rdata;

    assign full    = (r_count == CNW'(ENTRIES));
    assign append  = (r_mode == chnt_pkg::MODE_REGISTER) && !r_found && !full;
    assign new_idx = r_count[EIW-1:0];
    assign match   = (n_rdata == r_name);

    // The remainder takes four hash bits a cycle, most significant first.
    always_comb begin
        red = XW'({r_rem, r_hash[HW-1 -: 4]});
        if (red >= XW'(BUCKETS * 8)) red = red - XW'(BUCKETS * 8);
        if (red >= XW'(BUCKETS * 4)) red = red - XW'(BUCKETS * 4);
        if (red >= XW'(BUCKETS * 2)) red = red - XW'(BUCKETS * 2);
        if (red >= XW'(BUCKETS)) red = red - XW'(BUCKETS);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            chnt_pkg::S_CLEAR: if (r_cnt[BIW-1:0] == BIW'(BUCKETS - 1)) n_state = chnt_pkg::S_IDLE;
            chnt_pkg::S_IDLE:  if (!i_q_empty && !r_out_valid) n_state = chnt_pkg::S_MOD;
            chnt_pkg::S_MOD:   if (r_cnt[2:0] == 3'd7) n_state = chnt_pkg::S_BKT;
            chnt_pkg::S_BKT:   n_state = chnt_pkg::S_BKTD;
            chnt_pkg::S_BKTD:  n_state = b_rdata[EIW] ? chnt_pkg::S_ERD : chnt_pkg::S_FIN;
            chnt_pkg::S_ERD:   n_state = chnt_pkg::S_ECMP;
            chnt_pkg::S_ECMP: begin
                if (!match && l_rdata[EIW]) n_state = chnt_pkg::S_ERD;
                else n_state = chnt_pkg::S_FIN;
            end
            chnt_pkg::S_FIN:   n_state = (append && r_have_tail) ? chnt_pkg::S_LINK
                                                                 : chnt_pkg::S_IDLE;
            chnt_pkg::S_LINK:  n_state = chnt_pkg::S_IDLE;
            default:           n_state = chnt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_state == chnt_pkg::S_IDLE) && !i_q_empty && !r_out_valid;
        b_we    = 1'b0;
        b_waddr = r_rem;
        b_wdata = {1'b1, new_idx};
        n_we    = 1'b0;
        i_we    = 1'b0;
        i_waddr = r_found ? r_cur : new_idx;
        l_we    = 1'b0;
        l_waddr = new_idx;
        l_wdata = '0;
        case (r_state)
            chnt_pkg::S_CLEAR: begin
                b_we    = 1'b1;
                b_waddr = r_cnt[BIW-1:0];
                b_wdata = '0;
            end
            chnt_pkg::S_FIN: begin
                b_we = append && !r_have_tail;
                n_we = append;
                i_we = (r_mode == chnt_pkg::MODE_REGISTER) && (r_found || append);
                l_we = append;
            end
            chnt_pkg::S_LINK: begin
                l_we    = 1'b1;
                l_waddr = r_tail;
                l_wdata = {1'b1, r_cur};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chnt_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                chnt_pkg::S_CLEAR: r_cnt <= r_cnt + 1'b1;
                chnt_pkg::S_IDLE: begin
                    if (o_q_pop) begin
                        {r_tid, r_mode, r_name, r_hash} <= i_q_data;
                        r_cnt       <= '0;
                        r_rem       <= '0;
                        r_have_tail <= 1'b0;
                        r_found     <= 1'b0;
                    end
                end
                chnt_pkg::S_MOD: begin
                    r_rem  <= red[BIW-1:0];
                    r_hash <= r_hash << 4;
                    r_cnt  <= r_cnt + 1'b1;
                end
                chnt_pkg::S_BKTD: r_cur <= b_rdata[EIW-1:0];
                chnt_pkg::S_ECMP: begin
                    if (match) begin
                        r_found <= 1'b1;
                        r_fid   <= i_rdata;
                    end else begin
                        r_tail      <= r_cur;
                        r_have_tail <= 1'b1;
                        r_cur       <= l_rdata[EIW-1:0];
                    end
                end
                chnt_pkg::S_FIN: begin
                    r_out_valid <= 1'b1;
                    if (append) begin
                        r_cur   <= new_idx;
                        r_count <= r_count + 1'b1;
                    end
                    if (r_mode == chnt_pkg::MODE_REGISTER) begin
                        r_status  <= (!r_found && full) ? chnt_pkg::ST_FULL : chnt_pkg::ST_OK;
                        r_tid_out <= r_tid;
                    end else if (r_mode == chnt_pkg::MODE_WHOIS) begin
                        r_status  <= r_found ? chnt_pkg::ST_OK : chnt_pkg::ST_MISS;
                        r_tid_out <= r_found ? r_fid : '0;
                    end else begin
                        r_status  <= chnt_pkg::ST_MISS;
                        r_tid_out <= r_tid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    chnt_ram #(.W(EIW + 1), .D(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(r_rem), .o_rdata(b_rdata)
    );
    chnt_ram #(.W(NW), .D(ENTRIES)) u_name (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(new_idx), .i_wdata(r_name),
        .i_raddr(r_cur), .o_rdata(n_rdata)
    );
    chnt_ram #(.W(chnt_pkg::TID_W), .D(ENTRIES)) u_id (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(r_tid),
        .i_raddr(r_cur), .o_rdata(i_rdata)
    );
    chnt_ram #(.W(EIW + 1), .D(ENTRIES)) u_link (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(r_cur), .o_rdata(l_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_tid            = r_tid_out;
    assign o_bstat.clearing = (r_state == chnt_pkg::S_CLEAR);
    assign o_bstat.busy     = (r_state != chnt_pkg::S_IDLE) && (r_state != chnt_pkg::S_CLEAR);
endmodule
`default_nettype wire

// ===== rtl/core/chained_hash_name_table_unit.sv =====
// Top level of the chained hash name table: front, request queue and back.
// Depends on chnt_pkg, chnt_front, chnt_fifo, chnt_back and assert_macros.svh.
//
// A request arrives on the slave stream as one name character per item;
// tlast marks its final item, which also carries the mode (tuser) and the
// task id. Character items are taken whenever s_axis_tready is high. One
// result per request leaves on the master stream: a status and a task id.
// After the final character the back reduces the 32-bit hash to a bucket,
// four hash bits a cycle, reads the bucket head (S_BKT, S_BKTD), reads and
// compares each chain entry in turn (S_ERD, S_ECMP), and finishes in S_FIN,
// plus S_LINK when a new entry is linked behind a chain tail. The queue of
// two requests lets the front keep taking characters meanwhile.
// After reset the back clears the bucket heads, one per cycle, and
// s_axis_tready stays low until this is done.
// When the receiver stalls, the result waits in the output register; the
// back starts no new request until it is taken, and once the queue is full
// s_axis_tready falls.
`default_nettype none
`include "assert_macros.svh"
module chained_hash_name_table_unit #(
    parameter int NAME_LEN = chnt_pkg::NAME_LEN_DEF,
    parameter int BUCKETS  = chnt_pkg::BUCKETS_DEF,
    parameter int ENTRIES  = chnt_pkg::ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // name_char [6:0], tid_in [22:7], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // mode
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // status [1:0], tid_out [17:2], zero pad
);
    localparam int QW = chnt_pkg::TID_W + chnt_pkg::MODE_W
                      + NAME_LEN * chnt_pkg::CHAR_W + chnt_pkg::HASH_W;

    logic                          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0]                 q_wdata, q_rdata;
    chnt_pkg::t_bstat              bstat;
    logic [chnt_pkg::STATUS_W-1:0] status;
    logic [chnt_pkg::TID_W-1:0]    tid_out;

    chnt_front #(.NAME_LEN(NAME_LEN)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_char(s_axis_tdata[6:0]), .i_last(s_axis_tlast),
        .i_mode(s_axis_tuser), .i_tid(s_axis_tdata[22:7]),
        .i_q_full(q_full), .i_bstat(bstat),
        .o_q_push(q_push), .o_q_data(q_wdata)
    );

    chnt_fifo #(.W(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_wdata), .i_pop(q_pop),
        .o_data(q_rdata), .o_full(q_full), .o_empty(q_empty)
    );

    chnt_back #(.NAME_LEN(NAME_LEN), .BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(q_empty), .o_q_pop(q_pop), .i_q_data(q_rdata),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_status(status), .o_tid(tid_out), .o_bstat(bstat)
    );

    assign m_axis_tdata = {6'd0, tid_out, status};

    `CHNT_NEVER(a_no_req_while_clearing, i_clk, i_rst_n, s_axis_tready && bstat.clearing, "request taken during clearing pass")
    `CHNT_ASSERT(a_result_after_work, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(bstat.busy), "result without a request in progress")
    `CHNT_NEVER(a_status_code, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[1:0] == 2'd3), "undefined status code")
    `CHNT_NEVER(a_push_pop_order, i_clk, i_rst_n, q_pop && q_empty, "queue popped while empty")
endmodule
`default_nettype wire

// ===== tb/sv/chained_hash_name_table_unit_tb.sv =====
// Self-checking testbench of the chained hash name table unit: streams name requests,
// predicts each status and task id and compares them with the master stream.
// Depends on chnt_pkg and the RTL of chained_hash_name_table_unit.
`default_nettype none
module chained_hash_name_table_unit_tb;
    localparam int NLEN = chnt_pkg::NAME_LEN_DEF;
    localparam int NBKT = chnt_pkg::BUCKETS_DEF;
    localparam int NENT = chnt_pkg::ENTRIES_DEF;
    localparam int MW   = chnt_pkg::MODE_W;
    localparam int CHW  = chnt_pkg::CHAR_W;
    localparam int TW   = chnt_pkg::TID_W;
    localparam int HW   = chnt_pkg::HASH_W;
    localparam logic [MW-1:0] MODE_BAD_A = 2'd2;
    localparam logic [MW-1:0] MODE_BAD_B = 2'd3;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        chnt_pkg::t_status   status;
        logic [TW-1:0]       tid;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [23:0]        m_axis_tdata;

    chained_hash_name_table_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predicted table contents.
    logic [CHW-1:0]     pend_name [NLEN];
    int                 pend_len;
    logic [HW-1:0]      pend_hash;
    int                 bkt_head [NBKT];
    logic [CHW-1:0]     tbl_name [NENT][NLEN];
    logic [TW-1:0]      tbl_id [NENT];
    int                 tbl_link [NENT];
    int                 tbl_count;

    t_answer            answers_due [$];
    int                 send_gap_pct;
    int                 recv_stall_pct;
    bit                 hold_off;
    bit                 failed;
    longint             cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void clear_pending();
        for (int k = 0; k < NLEN; k++) pend_name[k] = '0;
        pend_len = 0;
        pend_hash = chnt_pkg::HASH_SEED;
    endfunction

    function automatic void reset_table();
        clear_pending();
        for (int b = 0; b < NBKT; b++) bkt_head[b] = -1;
        tbl_count = 0;
    endfunction

    function automatic bit same_name(int e);
        for (int k = 0; k < NLEN; k++)
            if (tbl_name[e][k] != pend_name[k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_lookup(logic [MW-1:0] mode, logic [CHW-1:0] ch,
                                           logic last, logic [TW-1:0] tid);
        int      bkt;
        int      cur;
        int      tail;
        bit      found;
        t_answer ans;
        if (ch != 0 && pend_len < NLEN) begin
            pend_name[pend_len] = ch;
            pend_len++;
            pend_hash = pend_hash * 33 + ch;
        end
        if (!last) return;
        bkt = pend_hash % NBKT;
        cur = bkt_head[bkt];
        tail = -1;
        found = 1'b0;
        while (cur >= 0) begin
            if (same_name(cur)) begin
                found = 1'b1;
                break;
            end
            tail = cur;
            cur = tbl_link[cur];
        end
        if (mode == chnt_pkg::MODE_REGISTER) begin
            ans.tid = tid;
            ans.status = chnt_pkg::ST_OK;
            if (found) begin
                tbl_id[cur] = tid;
            end else if (tbl_count >= NENT) begin
                ans.status = chnt_pkg::ST_FULL;
            end else begin
                for (int k = 0; k < NLEN; k++) tbl_name[tbl_count][k] = pend_name[k];
                tbl_id[tbl_count] = tid;
                tbl_link[tbl_count] = -1;
                if (tail >= 0) tbl_link[tail] = tbl_count;
                else bkt_head[bkt] = tbl_count;
                tbl_count++;
            end
        end else if (mode == chnt_pkg::MODE_WHOIS) begin
            ans.status = found ? chnt_pkg::ST_OK : chnt_pkg::ST_MISS;
            ans.tid = found ? tbl_id[cur] : '0;
        end else begin
            ans.status = chnt_pkg::ST_MISS;
            ans.tid = tid;
        end
        answers_due.push_back(ans);
        clear_pending();
    endfunction

    task automatic send_char(logic [MW-1:0] mode, logic [CHW-1:0] ch, logic last,
                             logic [TW-1:0] tid);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, tid, ch};
        s_axis_tuser <= mode;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_lookup(mode, ch, last, tid);
    endtask

    task automatic send_request(logic [MW-1:0] mode, string nm, logic [TW-1:0] tid);
        int n;
        n = nm.len();
        if (n == 0) begin
            send_char(mode, '0, 1'b1, tid);
            return;
        end
        for (int k = 0; k < n - 1; k++)
            send_char(MW'($urandom_range(3)), CHW'(nm[k]), 1'b0, TW'($urandom_range(65535)));
        send_char(mode, CHW'(nm[n-1]), 1'b1, tid);
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = chnt_pkg::t_status'(m_axis_tdata[1:0]);
            got.tid = m_axis_tdata[17:2];
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result status=%0d tid=%0h", $time,
                         got.status, got.tid);
                failed = 1'b1;
            end else begin
                want = answers_due.pop_front();
                if (got.status != want.status || got.tid != want.tid ||
                        m_axis_tdata[23:18] != 0) begin
                    $display("%0t: mismatch expected status=%0d tid=%0h, actual status=%0d tid=%0h",
                             $time, want.status, want.tid, got.status, got.tid);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic string rand_name(int pool);
        string s;
        int    n;
        s = "";
        if (pool > 0) begin
            // Small name space so that repeats and chain collisions are common.
            n = $urandom_range(pool - 1);
            s = $sformatf("n%0d", n);
            if (n % 5 == 0) s = {s, "_extended_name_text"};
        end else begin
            n = $urandom_range(20);
            for (int k = 0; k < n; k++) s = {s, string'(byte'($urandom_range(1, 127)))};
        end
        return s;
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(chnt_pkg::MODE_WHOIS, "", 16'h1234);
        send_request(chnt_pkg::MODE_REGISTER, "", 16'hFFFF);
        send_request(chnt_pkg::MODE_WHOIS, "", 16'h0);
        send_request(chnt_pkg::MODE_REGISTER, "alpha", 16'h0000);
        send_request(chnt_pkg::MODE_WHOIS, "alpha", 16'h5555);
        send_request(chnt_pkg::MODE_REGISTER, "alpha", 16'hABCD);
        send_request(chnt_pkg::MODE_WHOIS, "alpha", 16'h0);
        send_request(chnt_pkg::MODE_WHOIS, "beta", 16'h7777);
        send_request(MODE_BAD_A, "alpha", 16'h8001);
        send_request(MODE_BAD_B, "alpha", 16'hFFFE);
        send_request(chnt_pkg::MODE_REGISTER, "abcdefghijklmnopXYZ", 16'h4242);
        send_request(chnt_pkg::MODE_WHOIS, "abcdefghijklmnopQQ", 16'h0);
        send_char(chnt_pkg::MODE_REGISTER, 7'h7F, 1'b0, 16'h0);
        send_char(chnt_pkg::MODE_REGISTER, 7'h00, 1'b0, 16'h0);
        send_char(chnt_pkg::MODE_REGISTER, 7'h01, 1'b1, 16'h2468);
        send_char(chnt_pkg::MODE_WHOIS, 7'h7F, 1'b0, 16'h0);
        send_char(chnt_pkg::MODE_WHOIS, 7'h01, 1'b0, 16'h0);
        send_char(chnt_pkg::MODE_WHOIS, 7'h00, 1'b1, 16'h0);
    endtask

    task automatic test_fill_pool();
        for (int k = 0; k < NENT + 6; k++)
            send_request(chnt_pkg::MODE_REGISTER, $sformatf("pool%0d", k),
                         TW'($urandom_range(65535)));
        send_request(chnt_pkg::MODE_REGISTER, "alpha", 16'h1111);
        send_request(chnt_pkg::MODE_WHOIS, "pool3", 16'h0);
        send_request(chnt_pkg::MODE_WHOIS, $sformatf("pool%0d", NENT + 2), 16'h0);
    endtask

    task automatic test_random(int items);
        int sent;
        int pick;
        string nm;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 85) nm = rand_name(40);
            else nm = rand_name(0);
            if (pick < 40) begin
                send_request(chnt_pkg::MODE_REGISTER, nm, TW'($urandom_range(65535)));
            end else if (pick < 90) begin
                send_request(chnt_pkg::MODE_WHOIS, nm, TW'($urandom_range(65535)));
            end else begin
                send_request(MW'($urandom_range(2, 3)), nm, TW'($urandom_range(65535)));
            end
            sent += (nm.len() == 0) ? 1 : nm.len();
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 30; k++)
                send_request(chnt_pkg::MODE_WHOIS, rand_name(40), 16'h0);
        join
    endtask

    initial begin
        cycles = 0;
        failed = 1'b0;
        hold_off = 1'b0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        reset_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct = 26;
        recv_stall_pct = 80;
        test_directed();
        test_random(350);
        test_backpressure();
        send_gap_pct = 80;
        recv_stall_pct = 26;
        test_random(350);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(150);
        test_fill_pool();
        test_random(100);
        wait_drained();

        if (!failed && answers_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/chnt_pkg.sv
rtl/core/chnt_ram.sv
rtl/core/chnt_fifo.sv
rtl/core/chnt_front.sv
rtl/core/chnt_back.sv
rtl/core/chained_hash_name_table_unit.sv
tb/sv/chained_hash_name_table_unit_tb.sv
